### rtl/bds_pkg.sv
// Shared types and constants for the balanced delimiter splitter.
// No dependencies; every other file of the block imports this package.
package bds_pkg;

	localparam int CharBits     = 8;
	localparam int SepRegBits   = 64;
	localparam int CountBits    = 4;
	localparam int DataBits     = 64;
	localparam int AddrBits     = 4;

	// Register index codes, taken from paddr[3] (registers sit 8 bytes apart).
	localparam logic RegSepBytes = 1'b0;
	localparam logic RegSepCount = 1'b1;

	localparam logic [SepRegBits-1:0] SepBytesReset = 64'd44;
	localparam logic [CountBits-1:0]  SepCountReset = 4'd1;

	// Bytes that move the nesting depth.
	localparam logic [CharBits-1:0] CharQuote    = 8'h22;
	localparam logic [CharBits-1:0] CharParOpen  = 8'h28;
	localparam logic [CharBits-1:0] CharBrkOpen  = 8'h5B;
	localparam logic [CharBits-1:0] CharBrcOpen  = 8'h7B;
	localparam logic [CharBits-1:0] CharParClose = 8'h29;
	localparam logic [CharBits-1:0] CharBrkClose = 8'h5D;
	localparam logic [CharBits-1:0] CharBrcClose = 8'h7D;

	// Separator configuration handed from the register file to the scanner.
	typedef struct packed {
		logic [SepRegBits-1:0] sep_bytes;
		logic [CountBits-1:0]  sep_count;
	} bds_cfg_t;

	// First result for one byte, plus a flag that an empty token follows.
	typedef struct packed {
		logic [CharBits-1:0] char_out;
		logic                has_char;
		logic                token_done;
		logic                run_last;
		logic                second;
	} bds_result_t;

endpackage

### rtl/bds_char_if.sv
// Input channel of the splitter: one string byte per item.
// Depends on bds_pkg for the byte width.
interface bds_char_if import bds_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CharBits-1:0] char_in;
	logic                string_end;

	modport source (output valid, output char_in, output string_end, input ready);
	modport sink (input valid, input char_in, input string_end, output ready);
endinterface

### rtl/bds_token_if.sv
// Output channel of the splitter: one token event per item.
// Depends on bds_pkg for the byte width.
interface bds_token_if import bds_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CharBits-1:0] char_out;
	logic                has_char;
	logic                token_done;
	logic                run_last;

	modport source (output valid, output char_out, output has_char, output token_done,
		output run_last, input ready);
	modport sink (input valid, input char_out, input has_char, input token_done,
		input run_last, output ready);
endinterface

### rtl/bds_cfg.sv
// APB-style register file holding the separator bytes and separator count.
// Depends on bds_pkg.
module bds_cfg import bds_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [AddrBits-1:0] paddr,
	input  logic [DataBits-1:0] pwdata,
	output logic [DataBits-1:0] prdata,
	output logic                pready,
	output bds_cfg_t            cfg
);

	logic [SepRegBits-1:0] sep_bytes_q;
	logic [CountBits-1:0]  sep_count_q;
	logic                  wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// Register writes on the access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_bytes_q <= SepBytesReset;
			sep_count_q <= SepCountReset;
		end else if (wr_en) begin
			unique case (paddr[3])
				RegSepBytes: sep_bytes_q <= pwdata;
				RegSepCount: sep_count_q <= pwdata[CountBits-1:0];
				default: ;
			endcase
		end
	end

	// Read data mux.
	always_comb begin
		unique case (paddr[3])
			RegSepBytes: prdata = sep_bytes_q;
			RegSepCount: prdata = {{(DataBits-CountBits){1'b0}}, sep_count_q};
			default:     prdata = '0;
		endcase
	end

	assign cfg.sep_bytes = sep_bytes_q;
	assign cfg.sep_count = sep_count_q;

endmodule

### rtl/bds_scan.sv
// Nesting tracker and separator matcher: holds the depth and quote state
// and forms the result for the byte in the input register. Depends on bds_pkg.
module bds_scan import bds_pkg::*; #(
	parameter int SEPARATOR_SLOTS = 8,
	parameter int DEPTH_BITS      = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bds_cfg_t            cfg,
	input  logic [CharBits-1:0] char_s1,
	input  logic                end_s1,
	input  logic                advance,
	output bds_result_t         result
);

	localparam logic signed [DEPTH_BITS-1:0] DepthMax = {1'b0, {(DEPTH_BITS-1){1'b1}}};
	localparam logic signed [DEPTH_BITS-1:0] DepthMin = {1'b1, {(DEPTH_BITS-1){1'b0}}};

	logic signed [DEPTH_BITS-1:0] depth_q;
	logic signed [DEPTH_BITS-1:0] depth_next;
	logic                         quote_q;
	logic                         quote_next;
	logic                         inc;
	logic                         dec;
	logic [SEPARATOR_SLOTS-1:0]   lane_hit;
	logic                         is_sep;
	logic                         split;

	// One comparator per separator slot, enabled when the slot is in use.
	for (genvar i = 0; i < SEPARATOR_SLOTS; i++) begin : g_lane
		assign lane_hit[i] = (cfg.sep_count > CountBits'(i)) &&
			(cfg.sep_bytes[i*CharBits +: CharBits] == char_s1);
	end
	assign is_sep = |lane_hit;

	// Depth step: at most one of the increment and decrement applies.
	always_comb begin
		inc        = 1'b0;
		dec        = 1'b0;
		quote_next = quote_q;
		if (char_s1 == CharQuote) begin
			inc        = ~quote_q;
			dec        = quote_q;
			quote_next = ~quote_q;
		end
		if (char_s1 == CharParOpen || char_s1 == CharBrkOpen || char_s1 == CharBrcOpen) begin
			inc = 1'b1;
		end
		if (char_s1 == CharParClose || char_s1 == CharBrkClose ||
			char_s1 == CharBrcClose) begin
			dec = 1'b1;
		end
		depth_next = depth_q;
		if (inc && depth_q != DepthMax) begin
			depth_next = depth_q + DEPTH_BITS'(1);
		end else if (dec && depth_q != DepthMin) begin
			depth_next = depth_q - DEPTH_BITS'(1);
		end
	end

	assign split = is_sep && (depth_next == '0);

	// First result of the byte; a split on the final byte adds an empty token.
	always_comb begin
		if (split) begin
			result.char_out   = '0;
			result.has_char   = 1'b0;
			result.token_done = 1'b1;
			result.run_last   = ~end_s1;
			result.second     = end_s1;
		end else begin
			result.char_out   = char_s1;
			result.has_char   = 1'b1;
			result.token_done = end_s1;
			result.run_last   = 1'b1;
			result.second     = 1'b0;
		end
	end

	// State moves when the byte's result is loaded; the final byte clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			quote_q <= 1'b0;
		end else if (advance) begin
			if (end_s1) begin
				depth_q <= '0;
				quote_q <= 1'b0;
			end else begin
				depth_q <= depth_next;
				quote_q <= quote_next;
			end
		end
	end

endmodule

### rtl/balanced_delimiter_splitter.sv
// Channel   Role   Payload
// chars     sink   char_in, string_end
// tokens    source char_out, has_char, token_done, run_last
// APB       slave  separator_bytes at 0x0, separator_count at 0x8
//
// One byte is taken per cycle unless a stalled output or a pending empty token holds
// it back; its first result moves from the input register into the output register.
// A separator on the final byte gives two results, and the second holds the output register until taken.
// Reset is asynchronous and active low; it clears the depth, the quote flag,
// the valid flags and restores the register defaults.
// A stalled output backs up into the input register, then drops chars.ready.
// Depends on bds_pkg, bds_char_if, bds_token_if, bds_cfg and bds_scan.
module balanced_delimiter_splitter import bds_pkg::*; #(
	parameter int SEPARATOR_SLOTS = 8,
	parameter int DEPTH_BITS      = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	bds_char_if.sink            chars,
	bds_token_if.source         tokens,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [AddrBits-1:0] paddr,
	input  logic [DataBits-1:0] pwdata,
	output logic [DataBits-1:0] prdata,
	output logic                pready
);

	bds_cfg_t            cfg;
	bds_result_t         result;
	logic                s1_valid_q;
	logic [CharBits-1:0] char_s1;
	logic                end_s1;
	logic                out_valid_q;
	logic                second_q;
	logic [CharBits-1:0] char_out_q;
	logic                has_char_q;
	logic                token_done_q;
	logic                run_last_q;
	logic                load_out;
	logic                out_take;

	bds_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bds_scan #(
		.SEPARATOR_SLOTS (SEPARATOR_SLOTS),
		.DEPTH_BITS      (DEPTH_BITS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.char_s1 (char_s1),
		.end_s1  (end_s1),
		.advance (load_out),
		.result  (result)
	);

	// Handshake control: the input register drains into the output register
	// when that is free or being emptied with no empty token still to send.
	assign out_take    = out_valid_q & tokens.ready;
	assign load_out    = s1_valid_q & (~out_valid_q | (tokens.ready & ~second_q));
	assign chars.ready = ~s1_valid_q | load_out;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (chars.ready) begin
			s1_valid_q <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_in;
			end_s1  <= chars.string_end;
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
			second_q    <= result.second;
		end else if (out_take) begin
			if (second_q) begin
				second_q <= 1'b0;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output register payload; the trailing empty token replaces the first result.
	always_ff @(posedge clk) begin
		if (load_out) begin
			char_out_q   <= result.char_out;
			has_char_q   <= result.has_char;
			token_done_q <= result.token_done;
			run_last_q   <= result.run_last;
		end else if (out_take && second_q) begin
			char_out_q   <= '0;
			has_char_q   <= 1'b0;
			token_done_q <= 1'b1;
			run_last_q   <= 1'b1;
		end
	end

	assign tokens.valid      = out_valid_q;
	assign tokens.char_out   = char_out_q;
	assign tokens.has_char   = has_char_q;
	assign tokens.token_done = token_done_q;
	assign tokens.run_last   = run_last_q;

	// A pending empty token only exists behind a result on display.
	a_second_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> out_valid_q)
		else $error("empty token pending with no result shown");

	// A result that is not the byte's last must have its follower queued.
	a_not_last_has_follower: assert property (@(posedge clk) disable iff (!arst_n)
		(tokens.valid && !tokens.run_last) |-> second_q)
		else $error("result without run_last but no second result queued");

	// A result without a byte always ends a token and carries a zero byte.
	a_empty_result_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(tokens.valid && !tokens.has_char) |-> (tokens.token_done && tokens.char_out == '0))
		else $error("result without a byte is malformed");

	// Input back-pressure only arises when the input register holds an item.
	a_ready_low_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		!chars.ready |-> (s1_valid_q && out_valid_q))
		else $error("input stalled with a free pipeline");

endmodule

### bench/tb_balanced_delimiter_splitter.sv
// Self-checking bench for the balanced delimiter splitter: directed and random byte
// strings, checked result by result against a predictor of depth, quotes and splits.
// Depends on bds_pkg, bds_char_if, bds_token_if and balanced_delimiter_splitter.
module tb_balanced_delimiter_splitter;
	import bds_pkg::*;

	localparam int SepSlots     = 8;
	localparam int DepthBits    = 4;
	localparam int DepthMax     = (1 << (DepthBits - 1)) - 1;
	localparam int DepthMin     = -DepthMax - 1;
	localparam int PhaseCount   = 8;
	localparam int ItemsPerPhase = 220;
	localparam int HoldCycles   = 200;
	localparam int DrainCycles  = 16;
	localparam int RowCount     = 25;

	localparam logic [CharBits-1:0] CharComma  = 8'h2C;
	localparam logic [CharBits-1:0] CharLowerA = 8'h61;
	localparam logic [CharBits-1:0] CharLowerX = 8'h78;

	// One token event as it leaves the block.
	typedef struct packed {
		logic [CharBits-1:0] char_out;
		logic                has_char;
		logic                token_done;
		logic                run_last;
	} token_ev_t;

	// How a directed row is checked: against the predictor, or against a typed result.
	typedef enum logic [2:0] {
		ROW_FREE,
		ROW_TEXT,
		ROW_TEXT_END,
		ROW_SPLIT,
		ROW_SPLIT_END
	} row_kind_t;

	typedef struct packed {
		logic [CharBits-1:0] ch;
		logic                fin;
		row_kind_t           kind;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [AddrBits-1:0] paddr;
	logic [DataBits-1:0] pwdata;
	logic [DataBits-1:0] prdata;
	logic pready;

	bds_char_if  chars_bus ();
	bds_token_if tokens_bus ();

	balanced_delimiter_splitter #(
		.SEPARATOR_SLOTS(SepSlots),
		.DEPTH_BITS     (DepthBits)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_bus),
		.tokens (tokens_bus),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// Predictor state: separator setup and the scanner's depth and quote flag.
	logic [SepRegBits-1:0] sep_bytes = SepBytesReset;
	logic [CountBits-1:0]  sep_count = SepCountReset;
	int depth = 0;
	bit in_quote = 1'b0;
	int depth_hi = 0;
	int depth_lo = 0;

	token_ev_t token_q[$];

	int send_idle = 0;
	int recv_idle = 0;
	logic recv_hold = 1'b0;
	event hold_go;

	int errors = 0;
	int bytes_sent = 0;
	int strings_sent = 0;
	int results_checked = 0;
	int splits_seen = 0;
	int settings_used = 0;

	dir_row_t dir_rows [RowCount] = '{
		'{CharComma,    1'b0, ROW_SPLIT},
		'{CharLowerA,   1'b0, ROW_TEXT},
		'{CharParOpen,  1'b0, ROW_FREE},
		'{CharComma,    1'b0, ROW_FREE},
		'{CharParClose, 1'b0, ROW_FREE},
		'{CharComma,    1'b1, ROW_SPLIT_END},
		'{8'h00,        1'b0, ROW_TEXT},
		'{8'hFF,        1'b1, ROW_TEXT_END},
		'{CharQuote,    1'b0, ROW_FREE},
		'{CharComma,    1'b0, ROW_FREE},
		'{CharQuote,    1'b0, ROW_FREE},
		'{CharComma,    1'b0, ROW_FREE},
		'{CharBrkClose, 1'b0, ROW_FREE},
		'{CharComma,    1'b0, ROW_FREE},
		'{CharBrkOpen,  1'b0, ROW_FREE},
		'{CharComma,    1'b0, ROW_FREE},
		'{CharBrcOpen,  1'b0, ROW_FREE},
		'{CharBrcClose, 1'b0, ROW_FREE},
		'{CharParClose, 1'b0, ROW_FREE},
		'{CharComma,    1'b1, ROW_FREE},
		'{CharComma,    1'b0, ROW_FREE},
		'{CharBrcOpen,  1'b0, ROW_FREE},
		'{CharQuote,    1'b1, ROW_FREE},
		'{CharQuote,    1'b0, ROW_FREE},
		'{CharComma,    1'b1, ROW_FREE}
	};

	// Clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#8000000;
		$display("FAIL");
		$finish;
	end

	function automatic token_ev_t make_ev(input logic [CharBits-1:0] ch, input logic has,
		input logic done, input logic last);
		token_ev_t ev;
		ev.char_out   = ch;
		ev.has_char   = has;
		ev.token_done = done;
		ev.run_last   = last;
		return ev;
	endfunction

	// Append one expected token event behind the ones already waiting.
	function automatic void add_expected(input token_ev_t ev);
		token_q = {token_q, ev};
	endfunction

	// Move the depth by one step, holding it at the signed range limits.
	function automatic void bump_depth(input int delta);
		int nxt;
		nxt = depth + delta;
		if (nxt > DepthMax) nxt = DepthMax;
		if (nxt < DepthMin) nxt = DepthMin;
		depth = nxt;
		if (depth > depth_hi) depth_hi = depth;
		if (depth < depth_lo) depth_lo = depth;
	endfunction

	// A count beyond the slot number uses every slot.
	function automatic bit is_sep(input logic [CharBits-1:0] ch);
		int used;
		used = (sep_count > SepSlots) ? SepSlots : int'(sep_count);
		for (int i = 0; i < used; i++) begin
			if (sep_bytes[8*i +: 8] == ch) return 1'b1;
		end
		return 1'b0;
	endfunction

	// Predict the token events of one byte; the depth moves before the separator test.
	function automatic int scan_byte(input logic [CharBits-1:0] ch, input logic fin,
		output token_ev_t first, output token_ev_t second);
		bit split;
		int n;
		if (ch == CharQuote) begin
			bump_depth(in_quote ? -1 : 1);
			in_quote = !in_quote;
		end
		if (ch == CharParOpen || ch == CharBrkOpen || ch == CharBrcOpen) bump_depth(1);
		if (ch == CharParClose || ch == CharBrkClose || ch == CharBrcClose) bump_depth(-1);
		split = is_sep(ch) && depth == 0;
		second = make_ev(8'h00, 1'b0, 1'b1, 1'b1);
		if (split && fin) begin
			first = make_ev(8'h00, 1'b0, 1'b1, 1'b0);
			n = 2;
		end else if (split) begin
			first = make_ev(8'h00, 1'b0, 1'b1, 1'b1);
			n = 1;
		end else begin
			first = make_ev(ch, 1'b1, fin, 1'b1);
			n = 1;
		end
		if (fin) begin
			depth = 0;
			in_quote = 1'b0;
		end
		return n;
	endfunction

	task automatic note_mismatch(input string what, input int got, input int want);
		$display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	// Offer one byte, wait for it to be taken, then queue what it should produce.
	task automatic push_byte(input logic [CharBits-1:0] ch, input logic fin,
		input row_kind_t kind);
		token_ev_t first;
		token_ev_t second;
		int n;
		while ($urandom_range(99) < send_idle) begin
			chars_bus.valid <= 1'b0;
			@(posedge clk);
		end
		chars_bus.valid      <= 1'b1;
		chars_bus.char_in    <= ch;
		chars_bus.string_end <= fin;
		@(posedge clk);
		while (!chars_bus.ready) @(posedge clk);
		n = scan_byte(ch, fin, first, second);
		case (kind)
			ROW_TEXT: add_expected(make_ev(ch, 1'b1, 1'b0, 1'b1));
			ROW_TEXT_END: add_expected(make_ev(ch, 1'b1, 1'b1, 1'b1));
			ROW_SPLIT: add_expected(make_ev(8'h00, 1'b0, 1'b1, 1'b1));
			ROW_SPLIT_END: begin
				add_expected(make_ev(8'h00, 1'b0, 1'b1, 1'b0));
				add_expected(make_ev(8'h00, 1'b0, 1'b1, 1'b1));
			end
			default: begin
				add_expected(first);
				if (n == 2) add_expected(second);
			end
		endcase
		bytes_sent++;
		if (fin) strings_sent++;
	endtask

	// Stop offering bytes until every queued token event has come out.
	task automatic wait_drain();
		chars_bus.valid <= 1'b0;
		while (token_q.size() != 0) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready, then back to idle.
	task automatic write_reg(input logic idx, input logic [DataBits-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == RegSepBytes) sep_bytes = val;
		else sep_count = val[CountBits-1:0];
		@(posedge clk);
	endtask

	// Mostly separators, brackets, quotes and letters, so that splits happen often.
	function automatic logic [CharBits-1:0] pick_byte();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 20) return sep_bytes[8*$urandom_range(SepSlots-1) +: 8];
		if (r < 35) begin
			case ($urandom_range(2))
				0: return CharParOpen;
				1: return CharBrkOpen;
				default: return CharBrcOpen;
			endcase
		end
		if (r < 50) begin
			case ($urandom_range(2))
				0: return CharParClose;
				1: return CharBrkClose;
				default: return CharBrcClose;
			endcase
		end
		if (r < 58) return CharQuote;
		if (r < 85) return CharLowerA + CharBits'($urandom_range(25));
		return CharBits'($urandom_range(255));
	endfunction

	// Receiver: random stalls, plus a long hold-off on request.
	always @(posedge clk) begin
		if (!arst_n) tokens_bus.ready <= 1'b0;
		else tokens_bus.ready <= !recv_hold && ($urandom_range(99) >= recv_idle);
	end

	initial begin
		forever begin
			@(hold_go);
			recv_hold <= 1'b1;
			repeat (HoldCycles) @(posedge clk);
			recv_hold <= 1'b0;
		end
	end

	// Compare each accepted token event with the oldest expectation.
	always @(posedge clk) begin
		token_ev_t want;
		if (arst_n && tokens_bus.valid && tokens_bus.ready) begin
			if (token_q.size() == 0) begin
				note_mismatch("unexpected token event, char_out", int'(tokens_bus.char_out), -1);
			end else begin
				want = token_q.pop_front();
				if (tokens_bus.char_out !== want.char_out)
					note_mismatch("char_out", int'(tokens_bus.char_out), int'(want.char_out));
				if (tokens_bus.has_char !== want.has_char)
					note_mismatch("has_char", int'(tokens_bus.has_char), int'(want.has_char));
				if (tokens_bus.token_done !== want.token_done)
					note_mismatch("token_done", int'(tokens_bus.token_done),
						int'(want.token_done));
				if (tokens_bus.run_last !== want.run_last)
					note_mismatch("run_last", int'(tokens_bus.run_last), int'(want.run_last));
				results_checked++;
				if (!want.has_char) splits_seen++;
			end
		end
	end

	// Main sequence: reset, directed rows, random phases, then depth saturation.
	initial begin
		logic [SepRegBits-1:0] cfg_bytes [PhaseCount];
		logic [CountBits-1:0]  cfg_count [PhaseCount];

		arst_n               <= 1'b0;
		chars_bus.valid      <= 1'b0;
		chars_bus.char_in    <= '0;
		chars_bus.string_end <= 1'b0;
		psel                 <= 1'b0;
		penable              <= 1'b0;
		pwrite               <= 1'b0;
		paddr                <= '0;
		pwdata               <= '0;

		// Settings: default, eight mixed separators, count above the slots,
		// zero count, all-ones and all-zero bytes, random, and a plain comma.
		cfg_bytes[0] = 64'h0000_0000_0000_002C;  cfg_count[0] = 4'd1;
		cfg_bytes[1] = 64'h7C3A_2822_093B_202C;  cfg_count[1] = 4'd8;
		cfg_bytes[2] = 64'h7C3A_2822_093B_202C;  cfg_count[2] = 4'd15;
		cfg_bytes[3] = 64'h7C3A_2822_093B_202C;  cfg_count[3] = 4'd0;
		cfg_bytes[4] = 64'hFFFF_FFFF_FFFF_FFFF;  cfg_count[4] = 4'd8;
		cfg_bytes[5] = 64'h0000_0000_0000_0000;  cfg_count[5] = 4'd8;
		cfg_bytes[6] = {$urandom, $urandom};     cfg_count[6] = CountBits'($urandom_range(15));
		cfg_bytes[7] = 64'h0000_0000_0000_002C;  cfg_count[7] = 4'd1;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows under the reset configuration.
		send_idle = 26;
		recv_idle = 58;
		for (int i = 0; i < RowCount; i++) push_byte(dir_rows[i].ch, dir_rows[i].fin,
			dir_rows[i].kind);
		wait_drain();

		// Random strings, one separator setting per phase.
		for (int p = 0; p < PhaseCount; p++) begin
			if (p < 3) begin
				send_idle = 26;
				recv_idle = 58;
			end else if (p < 6) begin
				send_idle = 58;
				recv_idle = 26;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			write_reg(RegSepBytes, cfg_bytes[p]);
			write_reg(RegSepCount, {{(DataBits-CountBits){1'b0}}, cfg_count[p]});
			settings_used++;
			for (int k = 0; k < ItemsPerPhase; k++) begin
				if (p == 1 && k == 40) -> hold_go;
				if (p == 4 && k == 110) wait_drain();
				push_byte(pick_byte(), $urandom_range(11) == 0, ROW_FREE);
			end
			wait_drain();
		end

		// Drive the depth into both saturation limits, toggling the quote there.
		for (int i = 0; i < DepthMax + 3; i++) push_byte(CharParOpen, 1'b0, ROW_FREE);
		push_byte(CharQuote, 1'b0, ROW_FREE);
		push_byte(CharComma, 1'b0, ROW_FREE);
		push_byte(CharQuote, 1'b0, ROW_FREE);
		push_byte(CharLowerX, 1'b1, ROW_FREE);
		for (int i = 0; i < DepthMax + 3; i++) push_byte(CharParClose, 1'b0, ROW_FREE);
		push_byte(CharQuote, 1'b0, ROW_FREE);
		push_byte(CharComma, 1'b1, ROW_FREE);
		push_byte(CharComma, 1'b1, ROW_FREE);

		wait_drain();
		repeat (DrainCycles) @(posedge clk);

		$display("Sent %0d bytes in %0d strings over %0d separator settings; checked %0d events",
			bytes_sent, strings_sent, settings_used, results_checked);
		$display("including %0d splits; nesting depth ranged from %0d to %0d.",
			splits_seen, depth_lo, depth_hi);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
